/* src/futex_wait_wake_table_core_assert.svh */
// Assertion macros shared by the wait/wake table RTL.
`ifndef FUTEX_WAIT_WAKE_TABLE_CORE_ASSERT_SVH
`define FUTEX_WAIT_WAKE_TABLE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define FWWT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wait/wake table assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define FWWT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wait/wake table assertion failed");
`else
`define FWWT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FWWT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* src/fwwt_pkg.sv */
package fwwt_pkg;

    localparam int WAITER_SLOTS     = 256;
    localparam int HASH_BUCKETS     = 64;
    localparam int SLOTS_PER_BUCKET = 8;
    localparam int TASK_ID_BITS     = 16;

    localparam int ADDR_W      = 48;
    localparam int WORD_W      = 32;
    localparam int PAGE_SHIFT  = 12;
    localparam int SLOT_BITS   = $clog2(WAITER_SLOTS);
    localparam int ENTRY_BITS  = $clog2(WAITER_SLOTS + 1);
    localparam int BUCKET_BITS = $clog2(HASH_BUCKETS);
    localparam int POS_BITS    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int CNT_BITS    = $clog2(SLOTS_PER_BUCKET + 1);

    // The free-slot search covers one chunk of valid bits per cycle.
    localparam int SCAN_CHUNK     = (WAITER_SLOTS < 32) ? WAITER_SLOTS : 32;
    localparam int SCAN_CHUNKS    = WAITER_SLOTS / SCAN_CHUNK;
    localparam int CHUNK_IDX_BITS = (SCAN_CHUNKS > 1) ? $clog2(SCAN_CHUNKS) : 1;
    localparam int CHUNK_OFF_BITS = $clog2(SCAN_CHUNK);

    localparam logic [WORD_W-1:0] ALL_BITS = 32'hFFFF_FFFF;

    localparam logic [2:0] MODE_WAIT        = 3'd0;
    localparam logic [2:0] MODE_WAKE        = 3'd1;
    localparam logic [2:0] MODE_WAIT_BITSET = 3'd2;
    localparam logic [2:0] MODE_WAKE_BITSET = 3'd3;

    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_FAULT    = 3'd1;
    localparam logic [2:0] STS_MISMATCH = 3'd2;
    localparam logic [2:0] STS_NO_ROOM  = 3'd3;
    localparam logic [2:0] STS_UNSUP    = 3'd4;

    typedef struct packed {
        logic [2:0]        mode;
        logic [ADDR_W-1:0] address;
        logic [WORD_W-1:0] word_value;
        logic [WORD_W-1:0] current_word;
        logic              access_fault;
        logic [WORD_W-1:0] wake_bitset;
        logic [15:0]       task_id;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] woken_task;
        logic        task_valid;
        logic        block_caller;
        logic [3:0]  woken_count;
        logic        last;
    } t_rsp;

    typedef struct packed {
        logic [ADDR_W-1:0]       address;
        logic [WORD_W-1:0]       bits;
        logic [TASK_ID_BITS-1:0] task_id;
    } t_waiter;

    typedef logic [SLOTS_PER_BUCKET-1:0][ENTRY_BITS-1:0] t_row;

    typedef struct packed {
        logic                 set;
        logic                 clr;
        logic [SLOT_BITS-1:0] slot;
    } t_valid_upd;

    typedef struct packed {
        logic                 done;
        logic                 found;
        logic [SLOT_BITS-1:0] slot;
    } t_scan_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RESP,
        ST_ROW_RD,
        ST_ROW_GET,
        ST_FREE_SCAN,
        ST_WAIT_DONE,
        ST_POS_CHECK,
        ST_POS_CMP,
        ST_WAKE_DONE
    } t_state;

    // Page number folded twice, then reduced to the bucket count.
    function automatic logic [BUCKET_BITS-1:0] f_bucket(input logic [ADDR_W-1:0] addr);
        logic [ADDR_W-PAGE_SHIFT-1:0] h;
        h = addr[ADDR_W-1:PAGE_SHIFT];
        h = h ^ (h >> 16);
        h = h ^ (h >> 8);
        return h[BUCKET_BITS-1:0];
    endfunction

endpackage

/* src/fwwt_waiter_mem.sv */
module fwwt_waiter_mem (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [fwwt_pkg::SLOT_BITS-1:0]  i_waddr,
    input  fwwt_pkg::t_waiter               i_wdata,
    input  logic                            i_re,
    input  logic [fwwt_pkg::SLOT_BITS-1:0]  i_raddr,
    output fwwt_pkg::t_waiter               o_rdata
);
    import fwwt_pkg::*;

    t_waiter r_mem [WAITER_SLOTS];
    t_waiter r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/fwwt_bucket_mem.sv */
module fwwt_bucket_mem (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_we,
    input  logic [fwwt_pkg::BUCKET_BITS-1:0] i_waddr,
    input  fwwt_pkg::t_row                   i_wdata,
    input  logic                             i_re,
    input  logic [fwwt_pkg::BUCKET_BITS-1:0] i_raddr,
    output fwwt_pkg::t_row                   o_rdata
);
    import fwwt_pkg::*;

    // One valid bit per bucket row; a row never written reads as all empty.
    t_row                    r_mem [HASH_BUCKETS];
    logic [HASH_BUCKETS-1:0] r_row_valid;
    t_row                    r_rdata;
    logic                    r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rvalid    <= 1'b0;
        end else begin
            if (i_we) begin
                r_row_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvalid <= r_row_valid[i_raddr];
            end
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

/* src/fwwt_free_scan.sv */
module fwwt_free_scan (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fwwt_pkg::t_valid_upd           i_upd,
    input  logic                           i_scan_go,
    output fwwt_pkg::t_scan_rsp            o_scan,
    input  logic [fwwt_pkg::SLOT_BITS-1:0] i_probe_slot,
    output logic                           o_probe_valid
);
    import fwwt_pkg::*;

    logic [WAITER_SLOTS-1:0]                r_valid;
    logic [SCAN_CHUNKS-1:0][SCAN_CHUNK-1:0] w_view;
    logic [SCAN_CHUNK-1:0]                  w_chunk;
    logic [CHUNK_OFF_BITS-1:0]              w_off;
    logic                                   w_any_free;
    logic                                   r_active;
    logic                                   r_done;
    logic                                   r_found;
    logic [CHUNK_IDX_BITS-1:0]              r_chunk;
    logic [SLOT_BITS-1:0]                   r_slot;

    assign w_view  = r_valid;
    assign w_chunk = w_view[r_chunk];

    // Lowest clear bit of the current chunk.
    always_comb begin
        w_off      = '0;
        w_any_free = 1'b0;
        for (int i = SCAN_CHUNK - 1; i >= 0; i--) begin
            if (!w_chunk[i]) begin
                w_off      = CHUNK_OFF_BITS'(i);
                w_any_free = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_active <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            if (i_upd.set) begin
                r_valid[i_upd.slot] <= 1'b1;
            end
            if (i_upd.clr) begin
                r_valid[i_upd.slot] <= 1'b0;
            end
            if (i_scan_go) begin
                r_active <= 1'b1;
                r_done   <= 1'b0;
            end else if (r_active) begin
                if (w_any_free || r_chunk == CHUNK_IDX_BITS'(SCAN_CHUNKS - 1)) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_scan_go) begin
            r_chunk <= '0;
            r_found <= 1'b0;
        end else if (r_active) begin
            r_found <= w_any_free;
            r_slot  <= {r_chunk, w_off};
            r_chunk <= CHUNK_IDX_BITS'(r_chunk + 1'b1);
        end
    end

    assign o_scan.done   = r_done;
    assign o_scan.found  = r_found;
    assign o_scan.slot   = r_slot;
    assign o_probe_valid = r_valid[i_probe_slot];

endmodule

/* src/futex_wait_wake_table_core.sv */
// Futex-style wait/wake table. A request is taken when start is high and busy is low;
// busy then stays high while the request is worked on and falls in the cycle in which
// its final result appears, so the next request can be taken in that same cycle. Results
// appear on o_rsp for exactly one cycle, marked by o_result_strobe, and must be taken
// in that cycle: the block cannot be stalled by the receiver. Each result leaves through
// an output register in the cycle after the state that makes it. A faulting, unsupported
// or mismatching request gives one result, from ST_RESP. A wait reads its hashed bucket
// row (ST_ROW_RD, ST_ROW_GET), searches the waiter valid bits 32 slots per cycle until
// a free slot is found or every chunk is searched (ST_FREE_SCAN, in which the sequencer
// sees the search end), then commits or reports no room in ST_WAIT_DONE. A wake reads the
// bucket row, then visits the positions in order in ST_POS_CHECK; each live entry has its
// waiter record read from the waiter memory and compared in ST_POS_CMP. The walk stops at
// the row's end or once the wake count is reached, and ends with a summary result.
// The bucket rows and the valid bits clear at reset at once; no clearing pass is needed.
`include "futex_wait_wake_table_core_assert.svh"

module futex_wait_wake_table_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  fwwt_pkg::t_req i_req,
    output logic           o_result_strobe,
    output fwwt_pkg::t_rsp o_rsp
);
    import fwwt_pkg::*;

    // Sequencer state and the latched request.
    t_state                 r_state;
    t_state                 n_state;
    t_req                   r_req;
    t_req                   n_req;
    logic [BUCKET_BITS-1:0] r_bucket;
    logic [BUCKET_BITS-1:0] n_bucket;
    logic [2:0]             r_status;
    logic [2:0]             n_status;
    t_row                   r_row;
    t_row                   n_row;
    logic [CNT_BITS-1:0]    r_pos;
    logic [CNT_BITS-1:0]    n_pos;
    logic [CNT_BITS-1:0]    r_woken;
    logic [CNT_BITS-1:0]    n_woken;
    logic [SLOT_BITS-1:0]   r_slot;
    logic [SLOT_BITS-1:0]   n_slot;

    // Output register: results leave in the cycle after the state that makes them.
    logic                   r_strobe;
    logic                   n_strobe;
    t_rsp                   r_rsp;
    t_rsp                   n_rsp;

    logic                   w_accept;
    logic                   w_req_wait;
    logic                   w_cur_wait;
    logic [ENTRY_BITS-1:0]  w_entry;
    logic [SLOT_BITS-1:0]   w_entry_slot;
    logic                   w_entry_ok;
    logic                   w_wake_stop;
    logic                   w_match;
    logic [POS_BITS-1:0]    w_free_pos;
    logic                   w_free_pos_ok;

    // Memory, valid-bit and search control.
    logic                   bkt_we;
    logic                   bkt_re;
    t_row                   bkt_wdata;
    t_row                   bkt_rdata;
    logic                   wm_we;
    logic                   wm_re;
    t_waiter                wm_wdata;
    t_waiter                wm_rdata;
    t_valid_upd             valid_upd;
    logic                   scan_go;
    t_scan_rsp              scan_rsp;
    logic                   probe_valid;

    fwwt_bucket_mem u_bucket_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (bkt_we),
        .i_waddr (r_bucket),
        .i_wdata (bkt_wdata),
        .i_re    (bkt_re),
        .i_raddr (r_bucket),
        .o_rdata (bkt_rdata)
    );

    fwwt_waiter_mem u_waiter_mem (
        .i_clk   (i_clk),
        .i_we    (wm_we),
        .i_waddr (scan_rsp.slot),
        .i_wdata (wm_wdata),
        .i_re    (wm_re),
        .i_raddr (w_entry_slot),
        .o_rdata (wm_rdata)
    );

    fwwt_free_scan u_free_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_upd         (valid_upd),
        .i_scan_go     (scan_go),
        .o_scan        (scan_rsp),
        .i_probe_slot  (w_entry_slot),
        .o_probe_valid (probe_valid)
    );

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;

    assign w_req_wait = (i_req.mode == MODE_WAIT) || (i_req.mode == MODE_WAIT_BITSET);
    assign w_cur_wait = (r_req.mode == MODE_WAIT) || (r_req.mode == MODE_WAIT_BITSET);

    // The bucket entry under the wake cursor holds a slot number plus one; zero is empty.
    assign w_entry      = r_row[r_pos[POS_BITS-1:0]];
    assign w_entry_slot = SLOT_BITS'(w_entry - 1'b1);
    assign w_entry_ok   = (w_entry != '0) && (w_entry <= ENTRY_BITS'(WAITER_SLOTS))
                          && probe_valid;

    // A count with the top bit set wakes nobody; otherwise stop once the count is reached or the row ends.
    assign w_wake_stop = (r_pos == CNT_BITS'(SLOTS_PER_BUCKET)) || r_req.word_value[WORD_W-1]
                         || (WORD_W'(r_woken) >= r_req.word_value);

    // Shared compare: the waiter record just read against the latched request.
    assign w_match = (wm_rdata.address == r_req.address)
                     && ((r_req.mode != MODE_WAKE_BITSET)
                         || ((wm_rdata.bits & r_req.wake_bitset) != '0));

    // First empty position in the bucket row.
    always_comb begin
        w_free_pos    = '0;
        w_free_pos_ok = 1'b0;
        for (int i = SLOTS_PER_BUCKET - 1; i >= 0; i--) begin
            if (r_row[i] == '0) begin
                w_free_pos    = POS_BITS'(i);
                w_free_pos_ok = 1'b1;
            end
        end
    end

    always_comb begin
        wm_wdata.address = r_req.address;
        wm_wdata.bits    = ((r_req.mode == MODE_WAIT_BITSET) && (r_req.wake_bitset != '0))
                           ? r_req.wake_bitset : ALL_BITS;
        wm_wdata.task_id = TASK_ID_BITS'(r_req.task_id);
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if ((i_req.address == '0) || i_req.access_fault || (i_req.mode > MODE_WAKE_BITSET)
                        || (w_req_wait && (i_req.current_word != i_req.word_value))) begin
                        n_state = ST_RESP;
                    end else begin
                        n_state = ST_ROW_RD;
                    end
                end
            end
            ST_RESP:      n_state = ST_IDLE;
            ST_ROW_RD:    n_state = ST_ROW_GET;
            ST_ROW_GET:   n_state = w_cur_wait ? ST_FREE_SCAN : ST_POS_CHECK;
            ST_FREE_SCAN: n_state = scan_rsp.done ? ST_WAIT_DONE : ST_FREE_SCAN;
            ST_WAIT_DONE: n_state = ST_IDLE;
            ST_POS_CHECK: begin
                if (w_wake_stop) begin
                    n_state = ST_WAKE_DONE;
                end else if (w_entry_ok) begin
                    n_state = ST_POS_CMP;
                end
            end
            ST_POS_CMP:   n_state = ST_POS_CHECK;
            ST_WAKE_DONE: n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // Datapath control and result generation.
    always_comb begin
        n_req          = r_req;
        n_bucket       = r_bucket;
        n_status       = r_status;
        n_row          = r_row;
        n_pos          = r_pos;
        n_woken        = r_woken;
        n_slot         = r_slot;
        n_strobe       = 1'b0;
        n_rsp          = '0;
        bkt_we         = 1'b0;
        bkt_re         = 1'b0;
        bkt_wdata      = r_row;
        wm_we          = 1'b0;
        wm_re          = 1'b0;
        valid_upd      = '0;
        valid_upd.slot = scan_rsp.slot;
        scan_go        = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_req    = i_req;
                    n_bucket = f_bucket(i_req.address);
                    priority if ((i_req.address == '0) || i_req.access_fault) begin
                        n_status = STS_FAULT;
                    end else if (i_req.mode > MODE_WAKE_BITSET) begin
                        n_status = STS_UNSUP;
                    end else begin
                        n_status = STS_MISMATCH;
                    end
                end
            end
            ST_RESP: begin
                n_strobe     = 1'b1;
                n_rsp.status = r_status;
                n_rsp.last   = 1'b1;
            end
            ST_ROW_RD: begin
                bkt_re = 1'b1;
            end
            ST_ROW_GET: begin
                n_row   = bkt_rdata;
                n_pos   = '0;
                n_woken = '0;
                scan_go = w_cur_wait;
            end
            ST_FREE_SCAN: begin
            end
            ST_WAIT_DONE: begin
                n_strobe   = 1'b1;
                n_rsp.last = 1'b1;
                if (scan_rsp.found && w_free_pos_ok) begin
                    wm_we                 = 1'b1;
                    valid_upd.set         = 1'b1;
                    bkt_we                = 1'b1;
                    bkt_wdata[w_free_pos] = ENTRY_BITS'(ENTRY_BITS'(scan_rsp.slot) + 1'b1);
                    n_rsp.status          = STS_OK;
                    n_rsp.block_caller    = 1'b1;
                end else begin
                    n_rsp.status = STS_NO_ROOM;
                end
            end
            ST_POS_CHECK: begin
                if (!w_wake_stop) begin
                    if (w_entry_ok) begin
                        wm_re  = 1'b1;
                        n_slot = w_entry_slot;
                    end else begin
                        n_pos = CNT_BITS'(r_pos + 1'b1);
                    end
                end
            end
            ST_POS_CMP: begin
                n_pos = CNT_BITS'(r_pos + 1'b1);
                if (w_match) begin
                    valid_upd.clr                = 1'b1;
                    valid_upd.slot               = r_slot;
                    n_row[r_pos[POS_BITS-1:0]]   = '0;
                    n_woken                      = CNT_BITS'(r_woken + 1'b1);
                    n_strobe                     = 1'b1;
                    n_rsp.status                 = STS_OK;
                    n_rsp.woken_task             = 16'(wm_rdata.task_id);
                    n_rsp.task_valid             = 1'b1;
                end
            end
            ST_WAKE_DONE: begin
                bkt_we            = 1'b1;
                n_strobe          = 1'b1;
                n_rsp.status      = STS_OK;
                n_rsp.woken_count = 4'(r_woken);
                n_rsp.last        = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_bucket <= n_bucket;
        r_status <= n_status;
        r_row    <= n_row;
        r_pos    <= n_pos;
        r_woken  <= n_woken;
        r_slot   <= n_slot;
        r_rsp    <= n_rsp;
    end

    assign o_result_strobe = r_strobe;
    assign o_rsp           = r_rsp;

    // An idle sequencer that takes no request produces no result in the next cycle.
    `FWWT_ASSERT_NXT(a_no_spurious_result, i_clk, i_rst_n, (r_state == ST_IDLE) && !start, !o_result_strobe)
    // A released task is never the final result of its request, so the block stays busy.
    `FWWT_ASSERT_IMP(a_task_not_last, i_clk, i_rst_n, o_result_strobe && o_rsp.task_valid, !o_rsp.last && busy && (o_rsp.status == STS_OK))
    // The wake cursor never passes the end of a bucket row.
    `FWWT_ASSERT_IMP(a_pos_in_row, i_clk, i_rst_n, (r_state == ST_POS_CHECK) || (r_state == ST_POS_CMP), r_pos <= CNT_BITS'(SLOTS_PER_BUCKET))
    // Only a queued wait asks the caller to block, and it carries no count.
    `FWWT_ASSERT_IMP(a_block_only_wait, i_clk, i_rst_n, o_result_strobe && o_rsp.block_caller, o_rsp.last && (o_rsp.woken_count == 4'd0) && !o_rsp.task_valid)

endmodule
